[design/u8dec_pkg.sv]
// Package with the widths and constants of the UTF-8 byte decoder.
`default_nettype none

package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned HeldW  = 2;
  localparam int unsigned LenW   = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [HeldW-1:0] held_t;
  typedef logic [LenW-1:0]  len_t;

  localparam cp_t  ReplChar = 21'h00FFFD;
  localparam len_t LenTwo   = 3'd2;
  localparam len_t LenThree = 3'd3;
  localparam len_t LenFour  = 3'd4;

endpackage

`default_nettype wire

[design/u8dec_byte_if.sv]
// Valid/ready channel that carries one byte of UTF-8 text.
`default_nettype none

interface u8dec_byte_if import u8dec_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

[design/u8dec_cp_if.sv]
// Valid/ready channel that carries one decoded code point.
`default_nettype none

interface u8dec_cp_if import u8dec_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  code_point;
  logic replaced;
  logic run_last;
  logic text_end;

  modport source (output valid, output code_point, output replaced, output run_last,
                  output text_end, input ready);
  modport sink   (input valid, input code_point, input replaced, input run_last,
                  input text_end, output ready);
endinterface

`default_nettype wire

[design/utf8_byte_decoder.sv]
// Streaming UTF-8 decoder with replacement of malformed bytes.
// The first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while each byte causes at most one result and the
// output is ready; a byte that causes more results (up to four) holds off the next
// byte until its last result transfers; they play out one per cycle while ready.
// Reset clears the partial sequence and drops any results not yet transferred.
`default_nettype none

module utf8_byte_decoder import u8dec_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  u8dec_byte_if.sink     byte_i,
  u8dec_cp_if.source     cp_o
);

  held_t held_q, held_d;
  len_t  exp_q, exp_d;
  cp_t   bits_q, bits_d;
  len_t  rem_q, rem_d;
  cp_t   last_cp_q, last_cp_d;
  logic  last_rep_q, last_rep_d;
  logic  fin_q;

  logic  is_cont;
  logic  lead_path;
  len_t  held_inc;
  cp_t   gath;
  held_t pre_cnt;
  held_t post_cnt;
  logic  mid_vld;
  cp_t   mid_cp;
  logic  mid_rep;
  len_t  n_res;
  logic  in_fire;
  logic  out_fire;
  logic  is_last;

  assign is_last  = (rem_q == 3'd1);
  assign in_fire  = byte_i.valid && byte_i.ready;
  assign out_fire = cp_o.valid && cp_o.ready;

  assign byte_i.ready    = (rem_q == 3'd0) || (is_last && cp_o.ready);
  assign cp_o.valid      = (rem_q != 3'd0);
  assign cp_o.code_point = is_last ? last_cp_q : ReplChar;
  assign cp_o.replaced   = is_last ? last_rep_q : 1'b1;
  assign cp_o.run_last   = is_last;
  assign cp_o.text_end   = is_last && fin_q;

  always_comb begin
    is_cont   = (byte_i.text_byte[7:6] == 2'b10);
    held_inc  = {1'b0, held_q} + 3'd1;
    gath      = {bits_q[14:0], byte_i.text_byte[5:0]};
    lead_path = 1'b1;
    pre_cnt   = '0;
    mid_vld   = 1'b0;
    mid_cp    = ReplChar;
    mid_rep   = 1'b1;
    held_d    = held_q;
    exp_d     = exp_q;
    bits_d    = bits_q;

    if ((held_q != '0) && is_cont) begin
      lead_path = 1'b0;
      if (held_inc >= exp_q) begin
        mid_vld = 1'b1;
        mid_cp  = gath;
        mid_rep = 1'b0;
        held_d  = '0;
        exp_d   = '0;
        bits_d  = '0;
      end else begin
        held_d = held_inc[HeldW-1:0];
        bits_d = gath;
      end
    end

    // A broken sequence replaces every held byte, then the byte starts afresh.
    if (lead_path) begin
      pre_cnt = held_q;
      held_d  = '0;
      exp_d   = '0;
      bits_d  = '0;
      if (!byte_i.text_byte[7]) begin
        mid_vld = 1'b1;
        mid_cp  = {13'd0, byte_i.text_byte};
        mid_rep = 1'b0;
      end else if (byte_i.text_byte[7:6] == 2'b10) begin
        mid_vld = 1'b1;
      end else if (byte_i.text_byte[7:5] == 3'b110) begin
        held_d = 2'd1;
        exp_d  = LenTwo;
        bits_d = {16'd0, byte_i.text_byte[4:0]};
      end else if (byte_i.text_byte[7:4] == 4'b1110) begin
        held_d = 2'd1;
        exp_d  = LenThree;
        bits_d = {17'd0, byte_i.text_byte[3:0]};
      end else if (byte_i.text_byte[7:3] == 5'b11110) begin
        held_d = 2'd1;
        exp_d  = LenFour;
        bits_d = {18'd0, byte_i.text_byte[2:0]};
      end else begin
        mid_vld = 1'b1;
      end
    end

    // At the end of the text every byte still held is replaced.
    post_cnt = '0;
    if (byte_i.final_byte) begin
      post_cnt = held_d;
      held_d   = '0;
      exp_d    = '0;
      bits_d   = '0;
    end

    n_res = {1'b0, pre_cnt} + {2'd0, mid_vld} + {1'b0, post_cnt};

    if ((post_cnt != '0) || !mid_vld) begin
      last_cp_d  = ReplChar;
      last_rep_d = 1'b1;
    end else begin
      last_cp_d  = mid_cp;
      last_rep_d = mid_rep;
    end

    if (in_fire) begin
      rem_d = n_res;
    end else if (out_fire) begin
      rem_d = rem_q - 3'd1;
    end else begin
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      exp_q  <= '0;
      bits_q <= '0;
      rem_q  <= '0;
    end else begin
      rem_q <= rem_d;
      if (in_fire) begin
        held_q <= held_d;
        exp_q  <= exp_d;
        bits_q <= bits_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      last_cp_q  <= last_cp_d;
      last_rep_q <= last_rep_d;
      fin_q      <= byte_i.final_byte;
    end
  end

  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != '0) |-> ({1'b0, held_q} < exp_q))
    else $error("Partial sequence holds as many bytes as its lead promises.");

  a_idle_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> ((exp_q == '0) && (bits_q == '0)))
    else $error("Sequence state is not clear while nothing is held.");

  a_playout_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (rem_q > 3'd1)) |=> (rem_q == $past(rem_q) - 3'd1))
    else $error("Pending results were lost or repeated during playout.");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && byte_i.final_byte) |=> (held_q == '0))
    else $error("A partial sequence survived the end of the text.");

  a_final_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && byte_i.final_byte) |=> (rem_q != 3'd0))
    else $error("The final byte of the text caused no result.");

endmodule

`default_nettype wire

[sim/utf8_decode_checker.sv]
// Checker that predicts the decoded code points of the UTF-8 byte decoder and compares them.
`default_nettype none

module utf8_decode_checker import u8dec_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  u8dec_byte_if byte_mon,
  u8dec_cp_if   cp_mon,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int unsigned MaxResults  = 4;
  localparam int unsigned ReportLimit = 10;

  localparam byte_t TagMask      = 8'hC0;
  localparam byte_t ContTag      = 8'h80;
  localparam byte_t LeadTwo      = 8'hC0;
  localparam byte_t LeadThree    = 8'hE0;
  localparam byte_t LeadFour     = 8'hF0;
  localparam byte_t LeadBad      = 8'hF8;
  localparam byte_t PayloadTwo   = 8'h1F;
  localparam byte_t PayloadThree = 8'h0F;
  localparam byte_t PayloadFour  = 8'h07;

  typedef struct packed {
    cp_t  code_point;
    logic replaced;
    logic run_last;
    logic text_end;
  } cp_result_t;

  cp_result_t expected_cps_q[$];
  cp_result_t byte_results_q[$];
  len_t       seq_held;
  len_t       seq_len;
  cp_t        seq_bits;
  int         errors;

  initial begin
    seq_held = '0;
    seq_len  = '0;
    seq_bits = '0;
    errors   = 0;
  end

  function automatic void push_cp(cp_t cp, logic rep);
    cp_result_t r;
    if (byte_results_q.size() < MaxResults) begin
      r = '{code_point: cp, replaced: rep, run_last: 1'b0, text_end: 1'b0};
      byte_results_q = {byte_results_q, r};
    end
  endfunction

  function automatic void clear_seq();
    seq_held = '0;
    seq_len  = '0;
    seq_bits = '0;
  endfunction

  function automatic void flush_seq();
    for (int k = 0; k < seq_held; k++) push_cp(ReplChar, 1'b1);
    clear_seq();
  endfunction

  function automatic void take_lead(byte_t b);
    if (b < ContTag) begin
      push_cp(cp_t'(b), 1'b0);
    end else if (b < LeadTwo) begin
      push_cp(ReplChar, 1'b1);
    end else if (b < LeadThree) begin
      seq_held = 3'd1;
      seq_len  = LenTwo;
      seq_bits = cp_t'(b & PayloadTwo);
    end else if (b < LeadFour) begin
      seq_held = 3'd1;
      seq_len  = LenThree;
      seq_bits = cp_t'(b & PayloadThree);
    end else if (b < LeadBad) begin
      seq_held = 3'd1;
      seq_len  = LenFour;
      seq_bits = cp_t'(b & PayloadFour);
    end else begin
      push_cp(ReplChar, 1'b1);
    end
  endfunction

  function automatic void decode_byte(byte_t b, logic fin);
    int last;
    byte_results_q.delete();
    if (seq_held != 0) begin
      if ((b & TagMask) == ContTag) begin
        seq_bits = {seq_bits[CpW-7:0], b[5:0]};
        seq_held++;
        if (seq_held >= seq_len) begin
          push_cp(seq_bits, 1'b0);
          clear_seq();
        end
      end else begin
        flush_seq();
        take_lead(b);
      end
    end else begin
      take_lead(b);
    end
    if (fin) flush_seq();
    last = byte_results_q.size() - 1;
    if (last >= 0) begin
      byte_results_q[last].run_last = 1'b1;
      byte_results_q[last].text_end = fin;
    end
    expected_cps_q = {expected_cps_q, byte_results_q};
  endfunction

  function automatic void report_fault(string what, cp_result_t want, cp_result_t seen);
    errors++;
    if (errors <= ReportLimit) begin
      $display("%s: expected cp=%06h rep=%0b last=%0b end=%0b,",
               what, want.code_point, want.replaced, want.run_last, want.text_end,
               " got cp=%06h rep=%0b last=%0b end=%0b",
               seen.code_point, seen.replaced, seen.run_last, seen.text_end);
    end
  endfunction

  always @(posedge clk_i) begin
    cp_result_t seen;
    cp_result_t want;
    if (rst_ni) begin
      if (cp_mon.valid && cp_mon.ready) begin
        seen = '{code_point: cp_mon.code_point, replaced: cp_mon.replaced,
                 run_last: cp_mon.run_last, text_end: cp_mon.text_end};
        if (expected_cps_q.size() == 0) begin
          report_fault("unexpected code point", '0, seen);
        end else begin
          want = expected_cps_q.pop_front();
          if (seen !== want) report_fault("code point mismatch", want, seen);
        end
      end
      if (byte_mon.valid && byte_mon.ready) decode_byte(byte_mon.text_byte, byte_mon.final_byte);
    end
    fail_count_o <= errors;
    pending_o    <= expected_cps_q.size();
  end

endmodule

`default_nettype wire

[sim/tb_utf8_byte_decoder.sv]
// Testbench top that drives UTF-8 text into the byte decoder and gives the verdict.
`default_nettype none

module tb_utf8_byte_decoder;
  import u8dec_pkg::*;

  localparam int unsigned RandomItems  = 180;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 20;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  int    fail_count;
  int    pending;
  int    cycle_count;
  byte_t text_q[$];
  logic  last_q[$];

  always #2 clk_i = ~clk_i;

  u8dec_byte_if byte_ch ();
  u8dec_cp_if   cp_ch ();

  utf8_byte_decoder dut (
    .clk_i,
    .rst_ni,
    .byte_i (byte_ch),
    .cp_o   (cp_ch)
  );

  utf8_decode_checker decode_chk (
    .clk_i,
    .rst_ni,
    .byte_mon     (byte_ch),
    .cp_mon       (cp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic void add_byte(byte_t b, logic fin);
    text_q = {text_q, b};
    last_q = {last_q, fin};
  endfunction

  function automatic byte_t cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic void add_sequence(int unsigned len, int unsigned keep, logic fin);
    byte_t lead;
    case (len)
      1: begin
        lead = {1'b0, 7'($urandom_range(0, 127))};
      end
      2: begin
        lead = {3'b110, 5'($urandom_range(0, 31))};
      end
      3: begin
        lead = {4'b1110, 4'($urandom_range(0, 15))};
      end
      default: begin
        lead = {5'b11110, 3'($urandom_range(0, 7))};
      end
    endcase
    add_byte(lead, fin && keep == 1);
    for (int unsigned k = 2; k <= keep; k++) add_byte(cont_byte(), fin && k == keep);
  endfunction

  function automatic void add_noise(logic fin);
    int unsigned len;
    case ($urandom_range(0, 3))
      0: begin
        add_byte(byte_t'($urandom_range(0, 255)), fin);
      end
      1: begin
        add_byte(cont_byte(), fin);
      end
      2: begin
        add_byte(byte_t'($urandom_range(8'hF8, 8'hFF)), fin);
      end
      default: begin
        len = $urandom_range(2, 4);
        add_sequence(len, $urandom_range(1, len - 1), fin);
      end
    endcase
  endfunction

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    cp_ch.ready <= 1'b0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        0:       cp_ch.ready <= 1'b1;
        1:       cp_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       cp_ch.ready <= (tick % 7 >= 3);
        default: cp_ch.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned seq_len;
    logic        fin;
    byte_ch.valid      <= 1'b0;
    byte_ch.text_byte  <= '0;
    byte_ch.final_byte <= 1'b0;

    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF8, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hC0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hED, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBD, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hC0, 1'b1);
    add_byte(8'hBF, 1'b1);

    while (text_q.size() < RandomItems) begin
      fin = ($urandom_range(0, 14) == 0);
      if ($urandom_range(0, 4) != 0) begin
        seq_len = $urandom_range(1, 4);
        add_sequence(seq_len, seq_len, fin);
      end else begin
        add_noise(fin);
      end
    end
    last_q[last_q.size() - 1] = 1'b1;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 16);
    while (text_q.size() != 0) begin
      byte_ch.valid      <= 1'b1;
      byte_ch.text_byte  <= text_q.pop_front();
      byte_ch.final_byte <= last_q.pop_front();
      @(posedge clk_i);
      while (!byte_ch.ready) @(posedge clk_i);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          byte_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    byte_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
